/* src/llrs_pkg.sv */
package llrs_pkg;

    // grid geometry and field widths
    localparam int unsigned ROW_CELLS_DEF = 64;
    localparam int unsigned CELL_W        = 64;
    localparam int unsigned IDX_W         = 12;
    localparam int unsigned MASK_W        = 9;
    localparam int unsigned ROWS_W        = 13;
    localparam int unsigned NBR_W         = 4;

    // apb register map
    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;
    localparam logic [1:0]  REG_SURVIVE   = 2'd0;
    localparam logic [1:0]  REG_BIRTH     = 2'd1;
    localparam logic [1:0]  REG_ROW_COUNT = 2'd2;

    // register reset values
    localparam logic [MASK_W-1:0] SURVIVE_RST   = 9'd12;
    localparam logic [MASK_W-1:0] BIRTH_RST     = 9'd8;
    localparam logic [ROWS_W-1:0] ROW_COUNT_RST = 13'd75;

    // legal frame height
    localparam logic [ROWS_W-1:0] ROWS_MIN = 13'd3;
    localparam logic [ROWS_W-1:0] ROWS_MAX = 13'd4096;

    // one queued result; tail marks the dead closing row that follows it
    typedef struct packed {
        logic [CELL_W-1:0] cells;
        logic [IDX_W-1:0]  idx;
        logic              tail;
    } t_entry;

endpackage

/* src/llrs_cell_lane.sv */
module llrs_cell_lane (
    input  logic [2:0]                  i_above,
    input  logic [2:0]                  i_mid,
    input  logic [2:0]                  i_below,
    input  logic [llrs_pkg::MASK_W-1:0] i_survive_mask,
    input  logic [llrs_pkg::MASK_W-1:0] i_birth_mask,
    output logic                        o_alive
);
    import llrs_pkg::*;

    logic [NBR_W-1:0]  w_count;
    logic [MASK_W-1:0] w_rule;

    // eight-neighbor count
    assign w_count = {3'b0, i_above[0]} + {3'b0, i_above[1]} + {3'b0, i_above[2]}
                   + {3'b0, i_mid[0]} + {3'b0, i_mid[2]}
                   + {3'b0, i_below[0]} + {3'b0, i_below[1]} + {3'b0, i_below[2]};

    // live cells use the survive rule, dead cells the birth rule
    assign w_rule  = i_mid[1] ? i_survive_mask : i_birth_mask;
    assign o_alive = w_rule[w_count];

endmodule

/* src/llrs_out_queue.sv */
module llrs_out_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  llrs_pkg::t_entry            i_entry,
    output logic                        o_push_ready,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [llrs_pkg::CELL_W-1:0] o_cells,
    output logic [llrs_pkg::IDX_W-1:0]  o_idx,
    output logic                        o_last
);
    import llrs_pkg::*;

    // one slot more than a closing row needs, so input never waits on a steady flow
    localparam int unsigned DEPTH = 3;

    t_entry     r_slot [DEPTH];
    logic [1:0] r_wr_ptr, n_wr_ptr;
    logic [1:0] r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       r_phase, n_phase;
    t_entry     w_head;
    logic       w_xfer;
    logic       w_pop;

    assign w_head       = r_slot[r_rd_ptr];
    assign o_push_ready = (r_count != 2'(DEPTH));
    assign o_valid      = (r_count != 2'd0);
    assign w_xfer       = o_valid && i_ready;
    // head leaves once its closing row, if any, has gone too
    assign w_pop        = w_xfer && (!w_head.tail || r_phase);

    // head result, or the dead closing row after it
    always_comb begin
        if (r_phase) begin
            o_cells = '0;
            o_idx   = w_head.idx + IDX_W'(1);
            o_last  = 1'b1;
        end else begin
            o_cells = w_head.cells;
            o_idx   = w_head.idx;
            o_last  = 1'b0;
        end
    end

    // pointers, fill count and expansion phase
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == 2'(DEPTH - 1)) ? 2'd0 : r_wr_ptr + 2'd1;
        end
        n_rd_ptr = r_rd_ptr;
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == 2'(DEPTH - 1)) ? 2'd0 : r_rd_ptr + 2'd1;
        end
        n_count  = r_count + {1'b0, i_push} - {1'b0, w_pop};
        n_phase  = r_phase;
        if (w_pop) begin
            n_phase = 1'b0;
        end else if (w_xfer) begin
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 2'd0;
            r_phase  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_phase  <= n_phase;
        end
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

endmodule

/* src/life_like_automaton_row_step_unit.sv */
// Life-like automaton row stepper.
// Input channel (i_valid/o_ready, i_row_cells): the current generation, one
// grid row per transfer, top row first. Output channel (o_valid/i_ready):
// next-generation rows with their row index and an end-of-frame flag.
// Row 0 comes out dead as soon as it arrives; row r-1 comes out when row r
// arrives; the last row of a frame brings two results, the computed
// row before it and the dead last row flagged o_last_of_frame.
// Latency: with the queue empty a result is offered on the cycle after the
// transfer that causes it; the closing row is offered the cycle after the
// row before it is taken.
// Throughput: one row per cycle; all cells of a row are updated at once by
// one lane per inner column. A frame of R rows gives R results, so rows
// stream with no gap while the receiver keeps up.
// A three-entry result queue sits before the output, so a row is taken while
// results wait; when the receiver stalls the queue fills and o_ready drops.
// Rules and frame height are written over APB (0x0 survive mask, 0x4 birth
// mask, 0x8 row count); the user must write them only while no frame is in
// flight; the block does not enforce it. Reset clears the line buffers, the
// row counter and queue, and loads default rule B3/S23, 75 rows per frame.
module life_like_automaton_row_step_unit #(
    parameter int unsigned ROW_CELLS = llrs_pkg::ROW_CELLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [llrs_pkg::PADDR_W-1:0] paddr,
    input  logic [llrs_pkg::PDATA_W-1:0] pwdata,
    output logic [llrs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [llrs_pkg::CELL_W-1:0]  i_row_cells,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [llrs_pkg::CELL_W-1:0]  o_next_row_cells,
    output logic [llrs_pkg::IDX_W-1:0]   o_out_row_index,
    output logic                         o_last_of_frame
);
    import llrs_pkg::*;

    logic [MASK_W-1:0]    r_survive_mask;
    logic [MASK_W-1:0]    r_birth_mask;
    logic [ROWS_W-1:0]    r_row_count;
    logic [ROW_CELLS-1:0] r_older_row;
    logic [ROW_CELLS-1:0] r_newer_row;
    logic [IDX_W-1:0]     r_row_counter, n_row_counter;
    logic [IDX_W-1:0]     w_last;
    logic [CELL_W-1:0]    w_lane_row;
    logic                 w_accept;
    logic                 w_cfg_wr;
    logic                 w_push;
    t_entry               w_entry;

    // configuration registers
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_survive_mask <= SURVIVE_RST;
            r_birth_mask   <= BIRTH_RST;
            r_row_count    <= ROW_COUNT_RST;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                REG_SURVIVE:   r_survive_mask <= pwdata[MASK_W-1:0];
                REG_BIRTH:     r_birth_mask   <= pwdata[MASK_W-1:0];
                REG_ROW_COUNT: r_row_count    <= pwdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SURVIVE:   prdata = PDATA_W'(r_survive_mask);
            REG_BIRTH:     prdata = PDATA_W'(r_birth_mask);
            REG_ROW_COUNT: prdata = PDATA_W'(r_row_count);
            default:       prdata = '0;
        endcase
    end

    // index of the last row, frame height clamped to its legal range
    always_comb begin
        if (r_row_count < ROWS_MIN) begin
            w_last = IDX_W'(ROWS_MIN - ROWS_W'(1));
        end else if (r_row_count > ROWS_MAX) begin
            w_last = IDX_W'(ROWS_MAX - ROWS_W'(1));
        end else begin
            w_last = IDX_W'(r_row_count - ROWS_W'(1));
        end
    end

    // one lane per inner column; border columns and unused bits stay dead
    for (genvar c = 0; c < CELL_W; c++) begin : g_lane
        if (c >= 1 && c + 1 < ROW_CELLS) begin : g_inner
            llrs_cell_lane u_lane (
                .i_above        (r_older_row[c+1:c-1]),
                .i_mid          (r_newer_row[c+1:c-1]),
                .i_below        (i_row_cells[c+1:c-1]),
                .i_survive_mask (r_survive_mask),
                .i_birth_mask   (r_birth_mask),
                .o_alive        (w_lane_row[c])
            );
        end else begin : g_border
            assign w_lane_row[c] = 1'b0;
        end
    end

    // row sequencing and merge into one queued result
    assign w_accept = i_valid && o_ready;

    always_comb begin
        w_push        = 1'b0;
        w_entry       = '0;
        n_row_counter = r_row_counter;
        if (w_accept) begin
            if (r_row_counter == '0) begin
                w_push        = 1'b1;
                n_row_counter = IDX_W'(1);
            end else if (r_row_counter == IDX_W'(1)) begin
                n_row_counter = IDX_W'(2);
            end else begin
                w_push        = 1'b1;
                w_entry.cells = w_lane_row;
                w_entry.idx   = r_row_counter - IDX_W'(1);
                w_entry.tail  = (r_row_counter >= w_last);
                n_row_counter = w_entry.tail ? '0 : r_row_counter + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_counter <= '0;
            r_older_row   <= '0;
            r_newer_row   <= '0;
        end else begin
            r_row_counter <= n_row_counter;
            if (w_accept) begin
                r_older_row <= r_newer_row;
                r_newer_row <= i_row_cells[ROW_CELLS-1:0];
            end
        end
    end

    // result queue and closing-row expansion
    llrs_out_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_entry      (w_entry),
        .o_push_ready (o_ready),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cells      (o_next_row_cells),
        .o_idx        (o_out_row_index),
        .o_last       (o_last_of_frame)
    );

endmodule

/* src/llrs_checker.sv */
module llrs_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [llrs_pkg::CELL_W-1:0]  o_next_row_cells,
    input logic [llrs_pkg::IDX_W-1:0]   o_out_row_index,
    input logic                         o_last_of_frame
);
    import llrs_pkg::*;

    // queue is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_next_row_cells)
            && $stable(o_out_row_index) && $stable(o_last_of_frame))
        else $error("stalled result changed");

    // closing row is dead and never row 0 or 1
    a_last_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame |-> o_next_row_cells == '0
            && o_out_row_index != '0 && o_out_row_index != IDX_W'(1))
        else $error("bad closing row");

    // left border column is always dead
    a_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_next_row_cells[0])
        else $error("border cell alive");

    // closing row shows up right after its computed neighbor was taken
    a_close_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_frame && !$past(o_last_of_frame)
            |-> $past(o_valid && i_ready))
        else $error("closing row without preceding row");

endmodule

bind life_like_automaton_row_step_unit llrs_checker u_llrs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_next_row_cells (o_next_row_cells),
    .o_out_row_index  (o_out_row_index),
    .o_last_of_frame  (o_last_of_frame)
);
